/* rtl/core/pcs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types, codes and the 3x5 font for the POV column sequencer.
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int STORE_COLUMNS_DEFAULT = 256;

  typedef enum logic [1:0] {
    REQ_ADD  = 2'd0,
    REQ_TICK = 2'd1,
    REQ_TRIG = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_ADD  = 2'd1,
    ST_TICK = 2'd2
  } state_t;

  localparam logic       REG_REVERSE  = 1'b0;
  localparam logic       REG_TRIGGER  = 1'b1;

  localparam logic [7:0] FIRST_LETTER = 8'd97;
  localparam logic [7:0] LETTER_COUNT = 8'd26;
  localparam logic [4:0] BLANK_GLYPH  = 5'd26;
  localparam logic [7:0] BLANK_DRIVE  = 8'hFF;
  localparam logic [7:0] EMPTY_COLUMN = 8'h00;
  localparam logic [1:0] LAST_SLOT    = 2'd3;

  // three columns per glyph, first column in the low byte
  localparam logic [23:0] FONT_ROM [27] = '{
    24'h1E281E, 24'h142A3E, 24'h22221C, 24'h1C223E, 24'h2A2A3E, 24'h28283E,
    24'h0C2A1C, 24'h3E083E, 24'h022E02, 24'h3E2220, 24'h16083E, 24'h02023E,
    24'h1E183E, 24'h1E203E, 24'h1C221C, 24'h10283E, 24'h1E261E, 24'h16283E,
    24'h242A12, 24'h203E20, 24'h3E023E, 24'h3C023C, 24'h3C0C3C, 24'h360836,
    24'h3E0830, 24'h322A26, 24'h000000
  };

  function automatic logic [7:0] font_column(input logic [4:0] glyph,
                                             input logic [1:0] slot);
    logic [23:0] row;
    logic [7:0]  col;
    row = FONT_ROM[glyph];
    case (slot)
      2'd0:    col = row[7:0];
      2'd1:    col = row[15:8];
      2'd2:    col = row[23:16];
      default: col = EMPTY_COLUMN;
    endcase
    return col;
  endfunction

  function automatic logic [4:0] glyph_of(input logic [7:0] code);
    logic [7:0] ofs;
    ofs = code - FIRST_LETTER;
    return (code >= FIRST_LETTER && ofs < LETTER_COUNT) ? ofs[4:0] : BLANK_GLYPH;
  endfunction

endpackage

/* rtl/core/pcs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/pov_column_sequencer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pov_column_sequencer_core
// POV column sequencer: font lookup into a column store, ticked column output.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_axis    in   tvalid/tready        tuser[1:0] req_type, tdata[7:0] char_code
//  m_axis    out  tvalid/tready        tdata[7:0] led_drive, tdata[15:8] shown_column
//  cfg       in   cfg_we               cfg_index, cfg_data
//
//  Add: one column written per cycle over the store write port.
//  Tick: the store read, then the output register.
//  Trigger, unused code and ignored add: handled in idle, no busy state.
//  Synchronous reset; no clearing pass, only written columns are ever shown.
//  A tick waits in place while the output register is full and not taken.
// ----------------------------------------------------------------------------
module pov_column_sequencer_core #(
  parameter int STORE_COLUMNS = pcs_pkg::STORE_COLUMNS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] led_drive, [15:8] shown_column
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data
);

  localparam int CW   = $clog2(STORE_COLUMNS + 1);
  localparam int AW   = $clog2(STORE_COLUMNS);
  localparam int CMPW = ((CW > 8) ? CW : 8) + 1;

  pcs_pkg::state_t state, state_next;

  logic [CW-1:0] column_count;
  logic [7:0]    display_address;
  logic          moving_backward;
  logic          reverse_mode;
  logic          trigger_restart;
  logic [4:0]    glyph;
  logic [1:0]    slot;
  logic [7:0]    shown;
  logic          blank;

  logic          in_xfer;
  logic          out_free;
  logic          out_load;
  logic          store_full;
  logic          in_range;
  logic          at_last;
  logic [CMPW-1:0] count_ext;
  logic [CMPW-1:0] addr_ext;
  logic [7:0]    address_next;
  logic          backward_next;
  pcs_pkg::req_t req;

  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  assign req        = pcs_pkg::req_t'(s_axis_tuser);
  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign count_ext  = CMPW'(column_count);
  assign addr_ext   = CMPW'(display_address);
  assign store_full = (count_ext + CMPW'(4)) > CMPW'(STORE_COLUMNS);
  assign in_range   = addr_ext < count_ext;
  assign at_last    = (column_count != '0) && (addr_ext == count_ext - CMPW'(1));
  assign ram_waddr  = AW'(count_ext + CMPW'(slot));
  assign ram_wdata  = pcs_pkg::font_column(glyph, slot);

  // address advance after a tick
  always_comb begin
    backward_next = moving_backward;
    address_next  = display_address + 8'd1;
    if (reverse_mode) begin
      if (display_address == 8'd0) begin
        backward_next = 1'b0;
      end else if (at_last) begin
        backward_next = 1'b1;
      end
      address_next = backward_next ? display_address - 8'd1 : display_address + 8'd1;
    end else if (at_last && !trigger_restart) begin
      address_next = 8'd0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pcs_pkg::ST_IDLE: begin
        if (in_xfer && req == pcs_pkg::REQ_ADD && !store_full) begin
          state_next = pcs_pkg::ST_ADD;
        end else if (in_xfer && req == pcs_pkg::REQ_TICK) begin
          state_next = pcs_pkg::ST_TICK;
        end
      end
      pcs_pkg::ST_ADD: begin
        if (slot == pcs_pkg::LAST_SLOT) begin
          state_next = pcs_pkg::ST_IDLE;
        end
      end
      pcs_pkg::ST_TICK: begin
        if (out_free) begin
          state_next = pcs_pkg::ST_IDLE;
        end
      end
      default: state_next = pcs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    out_load      = 1'b0;
    case (state)
      pcs_pkg::ST_IDLE: begin
        s_axis_tready = !rst;
        ram_re        = s_axis_tvalid && req == pcs_pkg::REQ_TICK;
      end
      pcs_pkg::ST_ADD:  ram_we   = 1'b1;
      pcs_pkg::ST_TICK: out_load = out_free;
      default: ;
    endcase
  end

  pcs_ram #(
    .WIDTH(8),
    .DEPTH(STORE_COLUMNS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(AW'(display_address)),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= pcs_pkg::ST_IDLE;
      column_count    <= '0;
      display_address <= 8'd0;
      moving_backward <= 1'b0;
      reverse_mode    <= 1'b0;
      trigger_restart <= 1'b1;
      m_axis_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == pcs_pkg::REG_REVERSE) begin
          reverse_mode <= cfg_data;
        end else begin
          trigger_restart <= cfg_data;
        end
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (in_xfer && req == pcs_pkg::REQ_TICK) begin
        display_address <= address_next;
        moving_backward <= backward_next;
      end else if (in_xfer && req == pcs_pkg::REQ_TRIG) begin
        display_address <= 8'd0;
      end
      if (state == pcs_pkg::ST_ADD && slot == pcs_pkg::LAST_SLOT) begin
        column_count <= CW'(count_ext + CMPW'(4));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      glyph <= pcs_pkg::glyph_of(s_axis_tdata);
      slot  <= 2'd0;
      shown <= display_address;
      blank <= !in_range;
    end else if (state == pcs_pkg::ST_ADD) begin
      slot <= slot + 2'd1;
    end
    if (out_load) begin
      m_axis_tdata <= {shown, blank ? pcs_pkg::BLANK_DRIVE : ~ram_rdata};
    end
  end

endmodule

/* rtl/core/pcs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcs_checker
// Port-level checks for the POV column sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module pcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  logic tick_xfer;
  logic trig_xfer;

  assign tick_xfer = s_axis_tvalid && s_axis_tready && s_axis_tuser == pcs_pkg::REQ_TICK;
  assign trig_xfer = s_axis_tvalid && s_axis_tready && s_axis_tuser == pcs_pkg::REQ_TRIG;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(tick_xfer, 2))
    else $error("result without a tick transfer two cycles before");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    tick_xfer |=> !s_axis_tready)
    else $error("input taken while a tick is in flight");

  a_trigger_home: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) && $past(trig_xfer, 3) |-> m_axis_tdata[15:8] == 8'd0)
    else $error("tick after trigger did not show column 0");

endmodule

bind pov_column_sequencer_core pcs_checker u_pcs_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the POV column sequencer core. Adds letters, other
// codes and unused requests, ticks columns out and triggers the address back
// to zero under every forward and bounce setting. Each accepted request runs
// through a local column-store model. Each column transfer is checked against
// the oldest predicted column. Both stream sides idle at random, the output
// side holds off once for a long stretch and the store is filled past full.
// ----------------------------------------------------------------------------
module testbench;

  class pov_scoreboard;
    localparam int DEPTH      = pcs_pkg::STORE_COLUMNS_DEFAULT;
    localparam int FIRST_CODE = 97;
    localparam int LETTERS    = 26;
    localparam int BLANK      = 26;

    typedef struct packed {
      logic [7:0] column;
      logic [7:0] drive;
    } column_frame_t;

    logic [7:0]    columns [DEPTH];
    int            fill;
    logic [7:0]    addr;
    bit            backward;
    bit            reverse;
    bit            restart;
    column_frame_t expected_columns [$];
    int            errors;
    int            checked;
    int            stored;
    int            dropped;

    function new();
      fill     = 0;
      addr     = 8'd0;
      backward = 1'b0;
      reverse  = 1'b0;
      restart  = 1'b1;
      errors   = 0;
      checked  = 0;
      stored   = 0;
      dropped  = 0;
    endfunction

    // columns of one glyph, first column in the top byte
    function logic [23:0] glyph_columns(int g);
      case (g)
        0:  return 24'h1E281E;
        1:  return 24'h3E2A14;
        2:  return 24'h1C2222;
        3:  return 24'h3E221C;
        4:  return 24'h3E2A2A;
        5:  return 24'h3E2828;
        6:  return 24'h1C2A0C;
        7:  return 24'h3E083E;
        8:  return 24'h022E02;
        9:  return 24'h20223E;
        10: return 24'h3E0816;
        11: return 24'h3E0202;
        12: return 24'h3E181E;
        13: return 24'h3E201E;
        14: return 24'h1C221C;
        15: return 24'h3E2810;
        16: return 24'h1E261E;
        17: return 24'h3E2816;
        18: return 24'h122A24;
        19: return 24'h203E20;
        20: return 24'h3E023E;
        21: return 24'h3C023C;
        22: return 24'h3C0C3C;
        23: return 24'h360836;
        24: return 24'h30083E;
        25: return 24'h262A32;
        default: return 24'h000000;
      endcase
    endfunction

    function void set_register(logic index, logic value);
      if (index == pcs_pkg::REG_REVERSE) reverse = value;
      else restart = value;
    endfunction

    function void step_address();
      bit at_last;
      at_last = fill > 0 && int'(addr) == fill - 1;
      if (reverse) begin
        if (addr == 8'd0) backward = 1'b0;
        else if (at_last) backward = 1'b1;
        addr = backward ? addr - 8'd1 : addr + 8'd1;
      end else begin
        addr = (at_last && !restart) ? 8'd0 : addr + 8'd1;
      end
    endfunction

    function void note_request(pcs_pkg::req_t kind, logic [7:0] code);
      int            g;
      logic [23:0]   glyph;
      column_frame_t frame;
      case (kind)
        pcs_pkg::REQ_ADD: begin
          if (fill + 4 > DEPTH) begin
            dropped++;
            return;
          end
          g = (code >= FIRST_CODE && code < FIRST_CODE + LETTERS) ? code - FIRST_CODE : BLANK;
          glyph = glyph_columns(g);
          columns[fill]     = glyph[23:16];
          columns[fill + 1] = glyph[15:8];
          columns[fill + 2] = glyph[7:0];
          columns[fill + 3] = 8'h00;
          fill += 4;
          stored++;
        end
        pcs_pkg::REQ_TICK: begin
          frame.column = addr;
          frame.drive  = (int'(addr) < fill) ? ~columns[addr] : 8'hFF;
          expected_columns.push_back(frame);
          step_address();
        end
        pcs_pkg::REQ_TRIG: addr = 8'd0;
        default: ;
      endcase
    endfunction

    task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      $display("[%0t] %s: got %02h, expected %02h", $realtime, what, got, want);
      errors++;
    endtask

    task check_column(logic [15:0] word);
      column_frame_t want;
      checked++;
      if (expected_columns.size() == 0) begin
        report_mismatch("column transfer with none pending", word[7:0], 8'hxx);
        return;
      end
      want = expected_columns.pop_front();
      if (word[7:0] !== want.drive) report_mismatch("led_drive", word[7:0], want.drive);
      if (word[15:8] !== want.column)
        report_mismatch("shown_column", word[15:8], want.column);
    endtask

    function int pending();
      return expected_columns.size();
    endfunction
  endclass

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_AT     = 120;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] char_code
  logic [1:0]  s_axis_tuser = pcs_pkg::REQ_NONE; // [1:0] req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;          // [7:0] led_drive, [15:8] shown_column
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic        cfg_data = 1'b0;

  pov_scoreboard board = new();
  bit            steady = 1'b0;
  int            hold_left = 0;
  int            quiet_cycles = 0;
  int            requests = 0;

  always #5 clk = ~clk;

  pov_column_sequencer_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  task automatic send_request(pcs_pkg::req_t kind, logic [7:0] code);
    while (!steady && $urandom_range(99) < 15) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= code;
    do @(posedge clk); while (!s_axis_tready);
    board.note_request(kind, code);
    requests++;
  endtask

  task automatic drain_columns();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mode(bit reverse, bit restart);
    drain_columns();
    cfg_we    <= 1'b1;
    cfg_index <= pcs_pkg::REG_REVERSE;
    cfg_data  <= reverse;
    @(posedge clk);
    board.set_register(pcs_pkg::REG_REVERSE, reverse);
    cfg_index <= pcs_pkg::REG_TRIGGER;
    cfg_data  <= restart;
    @(posedge clk);
    board.set_register(pcs_pkg::REG_TRIGGER, restart);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int items, int add_pct, int trig_pct);
    int r;
    for (int n = 0; n < items; n++) begin
      r = $urandom_range(99);
      if (r < add_pct) begin
        if ($urandom_range(9) < 6) send_request(pcs_pkg::REQ_ADD, 8'(97 + $urandom_range(25)));
        else send_request(pcs_pkg::REQ_ADD, 8'($urandom_range(255)));
      end else if (r < add_pct + trig_pct) begin
        send_request(pcs_pkg::REQ_TRIG, 8'($urandom_range(255)));
      end else if (r < add_pct + trig_pct + 3) begin
        send_request(pcs_pkg::REQ_NONE, 8'($urandom_range(255)));
      end else begin
        send_request(pcs_pkg::REQ_TICK, 8'($urandom_range(255)));
      end
    end
  endtask

  // output side: check transfers, idle at random, hold off once
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        board.check_column(m_axis_tdata);
        if (board.checked == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || $urandom_range(99) >= 15;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles, %0d columns pending", $realtime,
               quiet_cycles, board.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(pcs_pkg::REQ_TICK, 8'h00);
    send_request(pcs_pkg::REQ_NONE, 8'hFF);
    send_request(pcs_pkg::REQ_TRIG, 8'h55);
    send_request(pcs_pkg::REQ_ADD, 8'd97);
    send_request(pcs_pkg::REQ_ADD, 8'd122);
    send_request(pcs_pkg::REQ_ADD, 8'd96);
    send_request(pcs_pkg::REQ_ADD, 8'd123);
    send_request(pcs_pkg::REQ_ADD, 8'h00);
    send_request(pcs_pkg::REQ_ADD, 8'hFF);
    for (int n = 0; n < 8; n++) send_request(pcs_pkg::REQ_TICK, 8'(n * 37));
    send_request(pcs_pkg::REQ_TRIG, 8'hAA);
    send_request(pcs_pkg::REQ_TICK, 8'h0F);

    // run on past the last column with no trigger and no restart at the last column
    set_mode(1'b0, 1'b1);
    run_phase(270, 5, 0);
    set_mode(1'b0, 1'b0);
    run_phase(60, 15, 6);
    steady = 1'b1;
    set_mode(1'b1, 1'b0);
    run_phase(60, 15, 6);
    steady = 1'b0;
    set_mode(1'b1, 1'b1);
    run_phase(60, 15, 6);
    set_mode(1'b0, 1'b0);
    run_phase(60, 15, 6);
    set_mode(1'b1, 1'b0);
    run_phase(60, 15, 6);
    set_mode(1'b0, 1'b1);
    run_phase(60, 15, 6);

    drain_columns();
    $display("Covered %0d requests: %0d characters stored, %0d dropped on a full store,",
             requests, board.stored, board.dropped);
    $display("%0d column transfers checked over all four forward and bounce settings",
             board.checked);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
